// ===== rtl/sdfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdfc_pkg
// Shared types and constants for the SysEx dump frame checker.
// ----------------------------------------------------------------------------
package sdfc_pkg;

    localparam int LONGEST_FRAME_DEF = 265;
    localparam int POS_W             = 9;
    localparam int CFG_COUNT         = 8;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_W             = 7;
    localparam int QUEUE_DEPTH       = 2;
    localparam int OUT_TDATA_W       = 48;

    localparam logic [7:0] START_BYTE   = 8'hF0;
    localparam logic [7:0] END_BYTE     = 8'hF7;
    localparam logic [7:0] WILDCARD_SUM = 8'h7F;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAKER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVTYPE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTI     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVETABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY   = 3'd7;

    // frame kinds
    localparam logic [2:0] KIND_SOUND     = 3'd0;
    localparam logic [2:0] KIND_MULTI     = 3'd1;
    localparam logic [2:0] KIND_WAVE      = 3'd2;
    localparam logic [2:0] KIND_WAVETABLE = 3'd3;
    localparam logic [2:0] KIND_GLOBAL    = 3'd4;
    localparam logic [2:0] KIND_DISPLAY   = 3'd5;
    localparam logic [2:0] KIND_NONE      = 3'd7;
    localparam int         KIND_COUNT     = 6;

    // frame status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_MAKER  = 3'd2;
    localparam logic [2:0] ST_TYPE   = 3'd3;
    localparam logic [2:0] ST_KIND   = 3'd4;
    localparam logic [2:0] ST_LENGTH = 3'd5;
    localparam logic [2:0] ST_END    = 3'd6;
    localparam logic [2:0] ST_CKSUM  = 3'd7;

    // one classified byte, front to back
    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       pay_valid;
        logic [7:0] pay_index;
        logic       is_cksum;
        logic [2:0] err;
        logic       len_err;
        logic [2:0] kind_out;
        logic       is_dev;
        logic       is_bank;
        logic       is_slot;
    } item_t;

endpackage

// ===== rtl/sdfc_front.sv =====
// ----------------------------------------------------------------------------
// sdfc_front
// Tracks frame position and kind, checks header and trailer bytes, tags
// payload bytes. Holds the configuration registers.
// ----------------------------------------------------------------------------
module sdfc_front #(
    parameter int LONGEST_FRAME = sdfc_pkg::LONGEST_FRAME_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sdfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sdfc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_take,
    input  logic [7:0]                     in_byte,
    input  logic                           in_eof,
    output sdfc_pkg::item_t                item
);
    import sdfc_pkg::*;

    localparam logic [9:0] LEN_LONG = 10'(LONGEST_FRAME);

    logic [CFG_W-1:0] cfg_reg [CFG_COUNT];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       kind_reg, kind_next;
    logic [2:0]       kind_match;
    logic [9:0]       len;
    logic [9:0]       pos_w;
    logic [9:0]       last;
    logic [2:0]       off;
    logic             kind_ok;

    function automatic logic [9:0] kind_len(input logic [2:0] k);
        logic [9:0] l;
        unique case (k)
            KIND_WAVE:    l = 10'd137;
            KIND_GLOBAL:  l = 10'd39;
            KIND_DISPLAY: l = 10'd88;
            default:      l = LEN_LONG;
        endcase
        return l;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[CFG_MAKER]     <= 7'd62;
            cfg_reg[CFG_DEVTYPE]   <= 7'd14;
            cfg_reg[CFG_SOUND]     <= 7'd16;
            cfg_reg[CFG_MULTI]     <= 7'd17;
            cfg_reg[CFG_WAVE]      <= 7'd18;
            cfg_reg[CFG_WAVETABLE] <= 7'd19;
            cfg_reg[CFG_GLOBAL]    <= 7'd20;
            cfg_reg[CFG_DISPLAY]   <= 7'd23;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // first matching message id wins
    always_comb
    begin
        kind_match = KIND_NONE;
        for (int k = KIND_COUNT - 1; k >= 0; k--)
        begin
            if (in_byte == {1'b0, cfg_reg[CFG_IDX_W'(k + 2)]})
                kind_match = 3'(k);
        end
    end

    always_comb
    begin
        kind_ok = (kind_reg != KIND_NONE) && (kind_reg != 3'd6);
        len     = kind_len(kind_reg);
        last    = len - 10'd1;
        off     = (kind_reg <= KIND_WAVETABLE) ? 3'd7 : 3'd5;
        pos_w   = {1'b0, pos_reg};

        item           = '0;
        item.data      = in_byte;
        item.eof       = in_eof;
        item.err       = ST_OK;
        kind_next      = kind_reg;

        if (pos_reg == 9'd0)
        begin
            if (in_byte != START_BYTE) item.err = ST_START;
        end
        else if (pos_reg == 9'd1)
        begin
            if (in_byte != {1'b0, cfg_reg[CFG_MAKER]}) item.err = ST_MAKER;
        end
        else if (pos_reg == 9'd2)
        begin
            if (in_byte != {1'b0, cfg_reg[CFG_DEVTYPE]}) item.err = ST_TYPE;
        end
        else if (pos_reg == 9'd3)
        begin
            item.is_dev = 1'b1;
        end
        else if (pos_reg == 9'd4)
        begin
            kind_next = kind_match;
            if (kind_match == KIND_NONE) item.err = ST_KIND;
        end
        else if (kind_ok)
        begin
            item.is_bank = (off == 3'd7) && (pos_reg == 9'd5);
            item.is_slot = (off == 3'd7) && (pos_reg == 9'd6);
            if ((pos_w >= {7'd0, off}) && (pos_w + 10'd2 < len))
            begin
                item.pay_valid = 1'b1;
                item.pay_index = 8'(pos_w - {7'd0, off});
            end
            else if (pos_w + 10'd2 == len)
            begin
                item.is_cksum = 1'b1;
            end
            else if (pos_w + 10'd1 == len)
            begin
                if (in_byte != END_BYTE) item.err = ST_END;
            end
        end

        if (pos_reg <= 9'd4)
            item.len_err = in_eof;
        else if (kind_ok)
            item.len_err = (in_eof && pos_w != last) || (!in_eof && pos_w == last);

        item.kind_out = (kind_next == KIND_NONE || kind_next == 3'd6) ? KIND_SOUND : kind_next;

        if (in_eof)
        begin
            pos_next  = '0;
            kind_next = KIND_SOUND;
        end
        else
        begin
            pos_next = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 9'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            kind_reg <= KIND_SOUND;
        end
        else if (in_take)
        begin
            pos_reg  <= pos_next;
            kind_reg <= kind_next;
        end
    end

endmodule

// ===== rtl/sdfc_queue.sv =====
// ----------------------------------------------------------------------------
// sdfc_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module sdfc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sdfc_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output sdfc_pkg::item_t pop_item
);
    import sdfc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/sdfc_back.sv =====
// ----------------------------------------------------------------------------
// sdfc_back
// Payload sum, checksum check, first-error tracking, captured header bytes
// and the output register.
// ----------------------------------------------------------------------------
module sdfc_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  sdfc_pkg::item_t                     q_item,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sdfc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);
    import sdfc_pkg::*;

    logic [6:0] sum_reg, sum_next;
    logic [2:0] ferr_reg, ferr_next;
    logic [7:0] dev_reg, dev_next;
    logic [7:0] bank_reg, bank_next;
    logic [7:0] slot_reg, slot_next;
    logic [2:0] err;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_last_reg;
    logic                   out_user_reg;

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        err = q_item.err;
        if (q_item.is_cksum)
        begin
            err = (q_item.data != WILDCARD_SUM && q_item.data != {1'b0, sum_reg})
                  ? ST_CKSUM : ST_OK;
        end
        if (err == ST_OK && q_item.len_err)
            err = ST_LENGTH;

        ferr_next = (ferr_reg == ST_OK) ? err : ferr_reg;
        sum_next  = q_item.pay_valid ? sum_reg + q_item.data[6:0] : sum_reg;
        dev_next  = q_item.is_dev  ? q_item.data : dev_reg;
        bank_next = q_item.is_bank ? q_item.data : bank_reg;
        slot_next = q_item.is_slot ? q_item.data : slot_reg;

        // byte[7:0] index[15:8] status[18:16] kind[21:19] dev[29:22]
        // bank[37:30] slot[45:38]
        out_data_next = '0;
        if (q_item.pay_valid)
        begin
            out_data_next[7:0]  = q_item.data;
            out_data_next[15:8] = q_item.pay_index;
        end
        if (q_item.eof)
        begin
            out_data_next[18:16] = ferr_next;
            out_data_next[21:19] = q_item.kind_out;
            out_data_next[29:22] = dev_next;
            out_data_next[37:30] = bank_next;
            out_data_next[45:38] = slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            ferr_reg <= ST_OK;
            dev_reg  <= '0;
            bank_reg <= '0;
            slot_reg <= '0;
        end
        else if (q_pop)
        begin
            if (q_item.eof)
            begin
                sum_reg  <= '0;
                ferr_reg <= ST_OK;
                dev_reg  <= '0;
                bank_reg <= '0;
                slot_reg <= '0;
            end
            else
            begin
                sum_reg  <= sum_next;
                ferr_reg <= ferr_next;
                dev_reg  <= dev_next;
                bank_reg <= bank_next;
                slot_reg <= slot_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (q_pop)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= q_item.eof;
            out_user_reg <= q_item.pay_valid;
        end
    end

endmodule

// ===== rtl/sysex_dump_frame_checker.sv =====
// Path: a byte accepted on the input is written into the queue and then
//   popped into the output register, from which it is offered on m_tdata.
// Throughput: one byte per cycle while the output is not stalled; the front
//   pushes into a two-entry queue and the back drains it into a single output
//   register, so stalls on the output fill the queue before input tready drops.
// Reset: rst_n clears frame position, kind, sum, error and captured bytes,
//   empties the queue and output, and loads the default register values.
// ----------------------------------------------------------------------------
// sysex_dump_frame_checker
// Byte-serial SysEx dump deframer: header/trailer/length/checksum checks, payload
// pass-through with index, verdict on the last byte.
// ----------------------------------------------------------------------------
module sysex_dump_frame_checker #(
    parameter int LONGEST_FRAME = sdfc_pkg::LONGEST_FRAME_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sdfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdfc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // data_byte
    input  logic                                s_tlast,  // end_of_frame
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // payload_byte[7:0] payload_index[15:8] frame_status[18:16]
    // frame_kind[21:19] device_number[29:22] bank_byte[37:30] slot_byte[45:38]
    output logic [sdfc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,  // frame_done
    output logic                                m_tuser   // payload_valid
);
    import sdfc_pkg::*;

    item_t front_item;
    item_t q_item;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  take;

    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;

    sdfc_front #(
        .LONGEST_FRAME (LONGEST_FRAME)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_take   (take),
        .in_byte   (s_tdata),
        .in_eof    (s_tlast),
        .item      (front_item)
    );

    sdfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (q_item)
    );

    sdfc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/sdfc_checker.sv =====
// ----------------------------------------------------------------------------
// sdfc_checker
// Port-level checks on the result stream of the frame checker.
// ----------------------------------------------------------------------------
module sdfc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sdfc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast,
    input logic                             m_tuser
);
    import sdfc_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("result changed while stalled");

    // verdict fields only on the last byte
    a_verdict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[45:16] == '0)
        else $error("verdict fields set before end of frame");

    // payload fields only on payload bytes
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[15:0] == '0)
        else $error("payload fields set on non-payload byte");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[21:19] != 3'd6 && m_tdata[21:19] != KIND_NONE)
        else $error("frame kind out of range");

endmodule

bind sysex_dump_frame_checker sdfc_checker u_sdfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
